FILE: src/frta_pkg.sv
`default_nettype none
package frta_pkg;

  localparam int unsigned REGION_COUNT_DEF = 16;
  localparam int unsigned ADDR_W = 32;

  localparam logic [31:0] PAGE_MASK_LOW  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK_HIGH = 32'hffff_f000;
  localparam logic [31:0] PAGE_BYTES     = 32'h0000_1000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] KIND_KERNEL = 2'd0;
  localparam logic [1:0] KIND_USER   = 2'd1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

endpackage
`default_nettype wire

FILE: src/frta_ram.sv
`default_nettype none
module frta_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/free_region_table_allocator.sv
`default_nettype none
// first-fit free region allocator. one request word in, one result word out.
// the region table sits in a single ram of REGION_COUNT entries; each entry is
// read in two steps (address then evaluate), and a request scans the entries in
// order and ends early when an entry fits or touches; a back join adds an extra
// read of the entry after, and a join with a neighbour adds a second write.
// entry valid bits make the table empty at reset with no clearing pass.
// a new request is taken when the scan is idle; a finished result waits in the
// output register.
module free_region_table_allocator #(
  parameter int unsigned REGION_COUNT = frta_pkg::REGION_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [1:0]  space_kind,
  input  wire logic [31:0] free_base,
  input  wire logic [31:0] size_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      alloc_base,
  output logic [1:0]       status
);
  import frta_pkg::*;

  localparam int unsigned IW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(REGION_COUNT - 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_READ     = 7'b0000010,
    S_EVAL     = 7'b0000100,
    S_NREAD    = 7'b0001000,
    S_NEVAL    = 7'b0010000,
    S_WR2      = 7'b0100000,
    S_PUT      = 7'b1000000
  } state_t;

  state_t            st;
  logic [IW-1:0]     k;
  logic [31:0]       total_memory;
  logic              rtype;
  logic [1:0]        kind;
  logic [31:0]       base_r, size_r;
  logic              ovf;
  logic [31:0]       prev_s, prev_l, cur_s, cur_l;
  logic [IW-1:0]     fe_idx;
  logic              fe_found;
  logic [REGION_COUNT-1:0] vld;
  logic              vld_rd;
  logic [IW-1:0]     wr2_addr;
  logic [31:0]       res_base;
  logic [1:0]        res_status;

  logic [IW-1:0]     raddr;
  logic [63:0]       rdata;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [63:0]       wdata;
  logic [31:0]       e_s, e_l, split, newlen;
  logic              fin, go_wr2, go_nread, kind_ok, empty_now;
  logic [IW-1:0]     wr2_next;
  logic [31:0]       fin_base;
  logic [1:0]        fin_status;

  frta_ram #(.WIDTH(64), .DEPTH(REGION_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr    = (st == S_NREAD) ? k + IW'(1) : k;
  assign e_s      = vld_rd ? rdata[63:32] : 32'd0;
  assign e_l      = vld_rd ? rdata[31:0]  : 32'd0;
  assign split    = total_memory >> 2;
  assign in_stall = (st != S_IDLE);
  assign empty_now = (e_s == 32'd0) && (e_l == 32'd0);

  always_comb begin
    case (kind)
      KIND_KERNEL: kind_ok = e_s < split;
      KIND_USER:   kind_ok = e_s >= split;
      default:     kind_ok = 1'b1;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    waddr      = k;
    wdata      = 64'd0;
    fin        = 1'b0;
    fin_base   = 32'd0;
    fin_status = ST_DONE;
    go_wr2     = 1'b0;
    go_nread   = 1'b0;
    wr2_next   = k;
    newlen     = e_l + size_r;
    case (st)
      S_EVAL: begin
        if (rtype == REQ_ALLOC) begin
          if (ovf) begin
            fin        = 1'b1;
            fin_status = ST_NO_FIT;
          end else if (e_l >= size_r && kind_ok) begin
            we       = 1'b1;
            wdata    = {e_s + size_r, e_l - size_r};
            fin      = 1'b1;
            fin_base = e_s;
          end else if (k == LAST) begin
            fin        = 1'b1;
            fin_status = ST_NO_FIT;
          end
        end else begin
          if (base_r + size_r == e_s) begin
            we = 1'b1;
            if (k != '0 && prev_s + prev_l == base_r) begin
              // front join that also closes the gap to the entry before
              waddr  = k - IW'(1);
              wdata  = {prev_s, prev_l + newlen};
              go_wr2 = 1'b1;
            end else begin
              wdata = {base_r, newlen};
              fin   = 1'b1;
            end
          end else if (e_s + e_l == base_r) begin
            if (k != LAST) begin
              go_nread = 1'b1;
            end else begin
              we    = 1'b1;
              wdata = {e_s, newlen};
              fin   = 1'b1;
            end
          end else if (k == LAST) begin
            fin = 1'b1;
            if (fe_found || empty_now) begin
              we    = 1'b1;
              waddr = fe_found ? fe_idx : k;
              wdata = {base_r, size_r};
            end else begin
              fin_status = ST_DROPPED;
            end
          end
        end
      end
      S_NEVAL: begin
        // back join, entry after is in the read word
        we = 1'b1;
        if (cur_s + cur_l == e_s) begin
          wdata    = {cur_s, cur_l + e_l};
          go_wr2   = 1'b1;
          wr2_next = k + IW'(1);
        end else begin
          wdata = {cur_s, cur_l};
          fin   = 1'b1;
        end
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = wr2_addr;
        fin   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      vld          <= '0;
      total_memory <= 32'd0;
      out_valid    <= 1'b0;
      k            <= '0;
      fe_found     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total_memory <= cfg_wr_data;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (st == S_PUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            rtype    <= req_type;
            kind     <= space_kind;
            base_r   <= free_base;
            k        <= '0;
            fe_found <= 1'b0;
            prev_s   <= 32'd0;
            prev_l   <= 32'd0;
            ovf      <= 1'b0;
            if (req_type == REQ_ALLOC && (size_bytes & PAGE_MASK_LOW) != 32'd0) begin
              ovf    <= (size_bytes & PAGE_MASK_HIGH) == PAGE_MASK_HIGH;
              size_r <= (size_bytes & PAGE_MASK_HIGH) + PAGE_BYTES;
            end else begin
              size_r <= size_bytes;
            end
            st <= S_READ;
          end
        end
        S_READ: begin
          vld_rd <= vld[k];
          st     <= S_EVAL;
        end
        S_NREAD: begin
          vld_rd <= vld[k + IW'(1)];
          st     <= S_NEVAL;
        end
        S_EVAL, S_NEVAL, S_WR2: begin
          if (fin) begin
            res_base   <= fin_base;
            res_status <= fin_status;
            st         <= S_PUT;
          end else if (go_wr2) begin
            wr2_addr <= wr2_next;
            st       <= S_WR2;
          end else if (go_nread) begin
            cur_s <= e_s;
            cur_l <= newlen;
            st    <= S_NREAD;
          end else begin
            if (empty_now && !fe_found) begin
              fe_found <= 1'b1;
              fe_idx   <= k;
            end
            prev_s <= e_s;
            prev_l <= e_l;
            k      <= k + IW'(1);
            st     <= S_READ;
          end
        end
        S_PUT: begin
          if (!out_valid || !out_stall) begin
            alloc_base <= res_base;
            status     <= res_status;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == S_PUT)) else $error("result without finish");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DONE || status == ST_NO_FIT || status == ST_DROPPED))
    else $error("bad status code");
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE || st == S_PUT) |-> !we) else $error("table write outside scan");
  a_free_base_zero: assert property (@(posedge clk) disable iff (rst)
    (st == S_PUT && rtype == REQ_FREE) |-> res_base == 32'd0)
    else $error("free returned a base");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_free_region_table_allocator.sv
`timescale 1ns / 1ps
module tb_free_region_table_allocator;
  import frta_pkg::*;

  localparam logic [1:0] KIND_ANY = 2'd2;
  localparam int NREG = 16;
  localparam int SETTLE = 60;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic        rtype;
    logic [1:0]  kind;
    logic [31:0] base;
    logic [31:0] size;
    int          gap;
  } req_word_t;

  typedef struct {
    logic [31:0] base;
    logic [1:0]  st;
  } res_word_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [31:0] cfg_wr_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        req_type = 0;
  logic [1:0]  space_kind = 0;
  logic [31:0] free_base = 0;
  logic [31:0] size_bytes = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] alloc_base;
  logic [1:0]  status;

  free_region_table_allocator u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .space_kind(space_kind), .free_base(free_base), .size_bytes(size_bytes),
    .out_valid(out_valid), .out_stall(out_stall), .alloc_base(alloc_base),
    .status(status)
  );

  always #1 clk = ~clk;

  // shadow of the region table and the total memory register
  logic [31:0] rgn_start [NREG];
  logic [31:0] rgn_len [NREG];
  logic [31:0] mem_total = 0;

  req_word_t pending_reqs[$];
  res_word_t expected_res[$];
  int mismatches = 0;
  int cycles = 0;
  bit calm_in = 0;
  bit calm_out = 0;

  function automatic res_word_t predict_alloc(logic [1:0] kind, logic [31:0] req);
    res_word_t r;
    logic [31:0] sz;
    logic [31:0] split;
    r.base = 0;
    r.st = ST_NO_FIT;
    sz = req;
    split = mem_total >> 2;
    if ((sz & PAGE_MASK_LOW) != 0) begin
      if ((sz & PAGE_MASK_HIGH) == PAGE_MASK_HIGH) return r;
      sz = (sz & PAGE_MASK_HIGH) + PAGE_BYTES;
    end
    for (int k = 0; k < NREG; k++) begin
      if (rgn_len[k] < sz) continue;
      if (kind == KIND_KERNEL && rgn_start[k] >= split) continue;
      if (kind == KIND_USER && rgn_start[k] < split) continue;
      r.base = rgn_start[k];
      r.st = ST_DONE;
      rgn_start[k] = rgn_start[k] + sz;
      rgn_len[k] = rgn_len[k] - sz;
      return r;
    end
    return r;
  endfunction

  function automatic res_word_t predict_free(logic [31:0] b, logic [31:0] sz);
    res_word_t r;
    r.base = 0;
    r.st = ST_DONE;
    for (int k = 0; k < NREG; k++) begin
      if (b + sz == rgn_start[k]) begin
        rgn_start[k] = b;
        rgn_len[k] = rgn_len[k] + sz;
        if (k > 0 && rgn_start[k-1] + rgn_len[k-1] == rgn_start[k]) begin
          rgn_len[k-1] = rgn_len[k-1] + rgn_len[k];
          rgn_start[k] = 0;
          rgn_len[k] = 0;
        end
        return r;
      end
      if (rgn_start[k] + rgn_len[k] == b) begin
        rgn_len[k] = rgn_len[k] + sz;
        if (k + 1 < NREG && rgn_start[k] + rgn_len[k] == rgn_start[k+1]) begin
          rgn_len[k] = rgn_len[k] + rgn_len[k+1];
          rgn_start[k+1] = 0;
          rgn_len[k+1] = 0;
        end
        return r;
      end
    end
    for (int k = 0; k < NREG; k++) begin
      if (rgn_start[k] == 0 && rgn_len[k] == 0) begin
        rgn_start[k] = b;
        rgn_len[k] = sz;
        return r;
      end
    end
    r.st = ST_DROPPED;
    return r;
  endfunction

  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        if (req_type == REQ_ALLOC) expected_res.push_back(predict_alloc(space_kind, size_bytes));
        else expected_res.push_back(predict_free(free_base, size_bytes));
      end
      if (pending_reqs.size() != 0 && pending_reqs[0].gap > 0) begin
        pending_reqs[0].gap--;
        in_valid <= 0;
      end else if (pending_reqs.size() != 0) begin
        req_word_t w;
        w = pending_reqs.pop_front();
        req_type <= w.rtype;
        space_kind <= w.kind;
        free_base <= w.base;
        size_bytes <= w.size;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor
  int hold_left = 0;
  always @(posedge clk) begin
    res_word_t e;
    int nxt;
    if (rst) begin
      out_stall <= 0;
    end else begin
      nxt = hold_left;
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word base=%h status=%0d",
                                         alloc_base, status);
        end else begin
          e = expected_res.pop_front();
          if (e.base !== alloc_base || e.st !== status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected base=%h status=%0d, got base=%h status=%0d",
                       e.base, e.st, alloc_base, status);
          end
        end
        if ($urandom_range(0, 40) == 0) calm_out = ~calm_out;
        nxt = draw_wait(calm_out);
      end
      if (nxt > 0) begin
        out_stall <= 1;
        hold_left <= nxt - 1;
      end else begin
        out_stall <= 0;
        hold_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic req_word_t mk(logic t, logic [1:0] k, logic [31:0] b, logic [31:0] s);
    req_word_t w;
    w.rtype = t;
    w.kind = k;
    w.base = b;
    w.size = s;
    if ($urandom_range(0, 30) == 0) calm_in = ~calm_in;
    w.gap = draw_wait(calm_in);
    return w;
  endfunction

  function automatic req_word_t rand_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return mk(REQ_FREE, 2'($urandom_range(0, 3)), 32'($urandom_range(1, 255)) << 12,
                32'($urandom_range(1, 4)) << 12);
    if (r < 85)
      return mk(REQ_ALLOC, 2'($urandom_range(0, 3)), 0,
                ($urandom_range(0, 9) == 0) ? 32'h0 : 32'($urandom_range(1, 3 * 4096)));
    return mk(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom, $urandom);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_total(logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    mem_total = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  initial begin
    logic [31:0] totals [5];
    for (int k = 0; k < NREG; k++) begin
      rgn_start[k] = 0;
      rgn_len[k] = 0;
    end
    totals[0] = 32'h0010_0000;
    totals[1] = 32'h0;
    totals[2] = 32'hffff_ffff;
    totals[3] = $urandom;
    totals[4] = 32'h0004_0000;
    repeat (3) @(posedge clk);
    rst <= 0;
    write_total(totals[0]);
    // empty table, rounding overflow, touch joins, space tests, wrapping spans
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_ANY, 0, 0));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_ANY, 0, 1));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_KERNEL, 0, 32'hffff_ffff));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_ANY, 0, 32'hffff_f001));
    pending_reqs.push_back(mk(REQ_FREE, KIND_KERNEL, 32'h0001_0000, 32'h4000));
    pending_reqs.push_back(mk(REQ_FREE, KIND_KERNEL, 32'h0001_4000, 32'h1000));
    pending_reqs.push_back(mk(REQ_FREE, KIND_KERNEL, 32'h0000_f000, 32'h1000));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_KERNEL, 0, 32'h1800));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_USER, 0, 32'h1000));
    pending_reqs.push_back(mk(REQ_FREE, KIND_ANY, 32'h0008_0000, 32'h2000));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_USER, 0, 32'h1000));
    pending_reqs.push_back(mk(REQ_ALLOC, 2'd3, 0, 32'h1000));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_ANY, 0, 32'h1000));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_ANY, 0, 32'h0));
    pending_reqs.push_back(mk(REQ_FREE, KIND_ANY, 32'hffff_ffff, 32'h1));
    pending_reqs.push_back(mk(REQ_FREE, KIND_ANY, 32'h0, 32'h0));
    pending_reqs.push_back(mk(REQ_FREE, KIND_ANY, 32'h1234_5000, 32'hffff_f000));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_ANY, 0, 32'hffff_f000));
    pending_reqs.push_back(mk(REQ_FREE, 2'd3, 32'hffff_ffff, 32'hffff_ffff));
    pending_reqs.push_back(mk(REQ_ALLOC, KIND_KERNEL, 0, 32'h0));
    for (int p = 0; p < 5; p++) begin
      if (p != 0) begin
        wait_idle();
        write_total(totals[p]);
      end
      for (int i = 0; i < 170; i++) pending_reqs.push_back(rand_req());
    end
    wait_idle();
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
